// ===== sv/projectile_rk4_step_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Projectile RK4 step unit: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PROJECTILE_RK4_STEP_UNIT_DEFINES_SVH
`define PROJECTILE_RK4_STEP_UNIT_DEFINES_SVH

// condition and consequence in the same cycle
`define PRK4_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequence in the cycle after the condition
`define PRK4_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== sv/prk4_pkg.sv =====
// ----------------------------------------------------------------------------
// Projectile RK4 step unit: package
// Types, codes and fixed constants of the integrator datapath.
// ----------------------------------------------------------------------------
package prk4_pkg;

  // widths
  localparam int COORD_W = 32;
  localparam int COEFF_W = 31;
  localparam int STEP_W  = 16;
  localparam int SUM_W   = 35;
  localparam int PROD_W  = 64;
  localparam int RND_W   = 40;
  localparam int ACC_W   = 42;
  localparam int CFG_IDX_W = 2;

  // divide-by-three sweep: eight bits a cycle over the rounded word
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = RND_W / DIV_BITS;

  // commands
  localparam logic CMD_LAUNCH = 1'b0;
  localparam logic CMD_STEP   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT = 2'd1;

  // reset values and physical constants
  localparam logic [COEFF_W-1:0] DRAG_RESET = 31'd23085000;
  localparam logic [COEFF_W-1:0] LIFT_RESET = 31'd31780;
  localparam logic signed [ACC_W-1:0] GRAVITY = 42'sd642908;
  localparam logic signed [COORD_W-1:0] GROUND_LIMIT = -32'sd65;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_RND, ST_DIV, ST_ACC, ST_KSUM, ST_DONE
  } state_t;

  typedef enum logic [1:0] {GRP_DERIV, GRP_STAGE, GRP_FINAL} group_t;

  typedef enum logic [1:0] {MA_DRAG, MA_LIFT, MA_STEP} mul_a_t;

  typedef enum logic [1:0] {MB_VX, MB_VY, MB_DER, MB_KSUM} mul_b_t;

  // rounding: coefficient (2^30), half step (2^13), full step (2^12),
  // sixth step (2^13 with the bias of 3*2^12, then divide by three)
  typedef enum logic [1:0] {RND_COEF, RND_HALF, RND_FULL, RND_SIXTH} rnd_mode_t;

  typedef enum logic [1:0] {BASE_ZERO, BASE_GRAV, BASE_ACC, BASE_STATE} base_sel_t;

  typedef enum logic [2:0] {DST_ACC, DST_D1, DST_D3, DST_STAGE, DST_STATE} dest_t;

  typedef struct packed {
    mul_a_t    a_sel;
    mul_b_t    b_sel;
    logic      neg;
    rnd_mode_t mode;
    base_sel_t base;
    dest_t     dest;
  } op_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = 42'sd2147483647;
    lo = -42'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== sv/projectile_rk4_step_unit.sv =====
// ----------------------------------------------------------------------------
// Projectile RK4 step unit
// Holds a projectile state (x, vx, y, vy) in Q16.16 and advances it by one
// fourth-order Runge-Kutta step with linear drag and lift, on one shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_stall   | command, start_x/y, start_vx/vy, time_step
// output   | out_valid / out_stall | pos_x, pos_y, vel_x, vel_y, landed
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A launch, or a step that finds the projectile below ground, keeps in_stall
// high only through the handover. An integrating step keeps it high through 28
// products (multiply, round, accumulate), four final updates (multiply, round,
// divide by three, accumulate), four slope-sum steps and the handover.
// The result waits in the output register while the next word is taken; while
// it is held the handover waits. Synchronous reset clears state, loads defaults.

`include "projectile_rk4_step_unit_defines.svh"

module projectile_rk4_step_unit (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic signed [31:0]  start_x,
  input  logic signed [31:0]  start_y,
  input  logic signed [31:0]  start_vx,
  input  logic signed [31:0]  start_vy,
  input  logic [15:0]         time_step,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  vel_x,
  output logic signed [31:0]  vel_y,
  output logic                landed,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int CW = prk4_pkg::COORD_W;
  localparam int SW = prk4_pkg::SUM_W;
  localparam int AW = prk4_pkg::ACC_W;
  localparam int RW = prk4_pkg::RND_W;
  localparam int DB = prk4_pkg::DIV_BITS;

  // control state
  prk4_pkg::state_t state, state_next;
  prk4_pkg::group_t group;
  logic [1:0]       idx;
  logic [1:0]       stage_n;
  logic [2:0]       div_cnt;

  // configuration and projectile state
  logic [prk4_pkg::COEFF_W-1:0] drag_coeff;
  logic [prk4_pkg::COEFF_W-1:0] lift_coeff;
  logic signed [CW-1:0] cur [4];
  logic                 ground_hit;

  // working registers
  logic [prk4_pkg::STEP_W-1:0] h_step;
  logic signed [CW-1:0]  tmp  [4];
  logic signed [CW-1:0]  der  [4];
  logic signed [SW-1:0]  ksum [4];
  logic signed [prk4_pkg::PROD_W-1:0] prod;
  logic [RW-1:0]         rnd;
  logic [1:0]            rem;
  logic signed [AW-1:0]  acc;

  // combinational datapath
  prk4_pkg::op_t         op;
  logic [prk4_pkg::COEFF_W-1:0] mul_a;
  logic signed [SW-1:0]  mul_b;
  logic signed [66:0]    prod_full;
  logic [63:0]           prod_abs;
  logic [63:0]           rnd_sum;
  logic [63:0]           rnd_shift;
  logic [RW-1:0]         rnd_next;
  logic [DB-1:0]         div_q;
  logic [1:0]            div_rem;
  logic signed [AW-1:0]  acc_base;
  logic signed [AW-1:0]  acc_term;
  logic signed [AW-1:0]  acc_sum;
  logic signed [CW-1:0]  acc_sat;

  logic in_acc;
  logic out_free;
  logic below_ground;

  assign in_stall     = (state != prk4_pkg::ST_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign cfg_ready    = 1'b1;
  assign out_free     = !out_valid || !out_stall;
  assign below_ground = (cur[2] < prk4_pkg::GROUND_LIMIT);

  // operation decode from sequencer position
  always_comb begin
    op.a_sel = prk4_pkg::MA_STEP;
    op.b_sel = prk4_pkg::MB_KSUM;
    op.neg   = 1'b0;
    op.mode  = prk4_pkg::RND_SIXTH;
    op.base  = prk4_pkg::BASE_STATE;
    op.dest  = prk4_pkg::DST_STATE;
    unique case (group)
      prk4_pkg::GRP_DERIV: begin
        op.mode = prk4_pkg::RND_COEF;
        op.neg  = 1'b1;
        unique case (idx)
          2'd0: begin
            op.a_sel = prk4_pkg::MA_DRAG;
            op.b_sel = prk4_pkg::MB_VX;
            op.base  = prk4_pkg::BASE_ZERO;
            op.dest  = prk4_pkg::DST_ACC;
          end
          2'd1: begin
            op.a_sel = prk4_pkg::MA_LIFT;
            op.b_sel = prk4_pkg::MB_VY;
            op.base  = prk4_pkg::BASE_ACC;
            op.dest  = prk4_pkg::DST_D1;
          end
          2'd2: begin
            op.a_sel = prk4_pkg::MA_DRAG;
            op.b_sel = prk4_pkg::MB_VY;
            op.base  = prk4_pkg::BASE_GRAV;
            op.dest  = prk4_pkg::DST_ACC;
          end
          default: begin
            op.a_sel = prk4_pkg::MA_LIFT;
            op.b_sel = prk4_pkg::MB_VX;
            op.neg   = 1'b0;
            op.base  = prk4_pkg::BASE_ACC;
            op.dest  = prk4_pkg::DST_D3;
          end
        endcase
      end
      prk4_pkg::GRP_STAGE: begin
        op.b_sel = prk4_pkg::MB_DER;
        op.mode  = (stage_n == 2'd2) ? prk4_pkg::RND_FULL : prk4_pkg::RND_HALF;
        op.dest  = prk4_pkg::DST_STAGE;
      end
      default: begin
        op.b_sel = prk4_pkg::MB_KSUM;
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (op.a_sel)
      prk4_pkg::MA_DRAG: mul_a = drag_coeff;
      prk4_pkg::MA_LIFT: mul_a = lift_coeff;
      default:           mul_a = {15'd0, h_step};
    endcase
    case (op.b_sel)
      prk4_pkg::MB_VX:  mul_b = {{(SW-CW){tmp[1][CW-1]}}, tmp[1]};
      prk4_pkg::MB_VY:  mul_b = {{(SW-CW){tmp[3][CW-1]}}, tmp[3]};
      prk4_pkg::MB_DER: mul_b = {{(SW-CW){der[idx][CW-1]}}, der[idx]};
      default:          mul_b = ksum[idx];
    endcase
  end

  assign prod_full = $signed({1'b0, mul_a}) * mul_b;

  // rounding to nearest, ties away from zero, on the magnitude
  always_comb begin
    prod_abs = prod[63] ? 64'(-prod) : 64'(prod);
    case (op.mode)
      prk4_pkg::RND_COEF: begin
        rnd_sum   = prod_abs + 64'd536870912;
        rnd_shift = rnd_sum >> 30;
      end
      prk4_pkg::RND_HALF: begin
        rnd_sum   = prod_abs + 64'd4096;
        rnd_shift = rnd_sum >> 13;
      end
      prk4_pkg::RND_FULL: begin
        rnd_sum   = prod_abs + 64'd2048;
        rnd_shift = rnd_sum >> 12;
      end
      default: begin
        rnd_sum   = prod_abs + 64'd12288;
        rnd_shift = rnd_sum >> 13;
      end
    endcase
    rnd_next = rnd_shift[RW-1:0];
  end

  // divide by three, one byte of the word per cycle, msb first
  always_comb begin
    logic [2:0] r3;
    logic [1:0] r;
    r     = rem;
    div_q = '0;
    for (int b = 0; b < DB; b++) begin
      r3 = {r, rnd[RW-1-b]};
      if (r3 >= 3'd3) begin
        r3 = r3 - 3'd3;
        div_q[DB-1-b] = 1'b1;
      end
      r = r3[1:0];
    end
    div_rem = r;
  end

  // accumulate and saturate
  always_comb begin
    case (op.base)
      prk4_pkg::BASE_ZERO: acc_base = '0;
      prk4_pkg::BASE_GRAV: acc_base = -prk4_pkg::GRAVITY;
      prk4_pkg::BASE_ACC:  acc_base = acc;
      default:             acc_base = {{(AW-CW){cur[idx][CW-1]}}, cur[idx]};
    endcase
    acc_term = $signed({2'b00, rnd});
    if (prod[63] ^ op.neg) begin
      acc_term = -acc_term;
    end
    acc_sum = acc_base + acc_term;
    acc_sat = prk4_pkg::sat32(acc_sum);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prk4_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      prk4_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (command == prk4_pkg::CMD_LAUNCH || below_ground) begin
            state_next = prk4_pkg::ST_DONE;
          end else begin
            state_next = prk4_pkg::ST_MUL;
          end
        end
      end
      prk4_pkg::ST_MUL: state_next = prk4_pkg::ST_RND;
      prk4_pkg::ST_RND: begin
        state_next = (group == prk4_pkg::GRP_FINAL) ? prk4_pkg::ST_DIV
                                                    : prk4_pkg::ST_ACC;
      end
      prk4_pkg::ST_DIV: begin
        if (div_cnt == 3'(prk4_pkg::DIV_STEPS - 1)) begin
          state_next = prk4_pkg::ST_ACC;
        end
      end
      prk4_pkg::ST_ACC: begin
        if (idx == 2'd3 && group == prk4_pkg::GRP_DERIV) begin
          state_next = prk4_pkg::ST_KSUM;
        end else if (idx == 2'd3 && group == prk4_pkg::GRP_FINAL) begin
          state_next = prk4_pkg::ST_DONE;
        end else begin
          state_next = prk4_pkg::ST_MUL;
        end
      end
      prk4_pkg::ST_KSUM: state_next = prk4_pkg::ST_MUL;
      prk4_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = prk4_pkg::ST_IDLE;
        end
      end
      default: state_next = prk4_pkg::ST_IDLE;
    endcase
  end

  // sequencer position, projectile state, coefficients, output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      group      <= prk4_pkg::GRP_DERIV;
      idx        <= '0;
      stage_n    <= '0;
      div_cnt    <= '0;
      drag_coeff <= prk4_pkg::DRAG_RESET;
      lift_coeff <= prk4_pkg::LIFT_RESET;
      for (int i = 0; i < 4; i++) begin
        cur[i] <= '0;
      end
      ground_hit <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          prk4_pkg::REG_DRAG: drag_coeff <= cfg_data[prk4_pkg::COEFF_W-1:0];
          prk4_pkg::REG_LIFT: lift_coeff <= cfg_data[prk4_pkg::COEFF_W-1:0];
          default: ;
        endcase
      end

      // word intake
      if (state == prk4_pkg::ST_IDLE && in_acc) begin
        if (command == prk4_pkg::CMD_LAUNCH) begin
          cur[0]     <= start_x;
          cur[1]     <= start_vx;
          cur[2]     <= start_y;
          cur[3]     <= start_vy;
          ground_hit <= 1'b0;
        end else if (below_ground) begin
          ground_hit <= 1'b1;
        end
        group   <= prk4_pkg::GRP_DERIV;
        idx     <= '0;
        stage_n <= '0;
      end

      // divider step count
      if (state == prk4_pkg::ST_RND) begin
        div_cnt <= '0;
      end else if (state == prk4_pkg::ST_DIV) begin
        div_cnt <= div_cnt + 3'd1;
      end

      // final update writes the state; sequencer advance
      if (state == prk4_pkg::ST_ACC) begin
        if (op.dest == prk4_pkg::DST_STATE) begin
          cur[idx] <= acc_sat;
        end
        if (group == prk4_pkg::GRP_STAGE && idx == 2'd3) begin
          group   <= prk4_pkg::GRP_DERIV;
          idx     <= '0;
          stage_n <= stage_n + 2'd1;
        end else if (!(group == prk4_pkg::GRP_DERIV && idx == 2'd3)) begin
          idx <= idx + 2'd1;
        end
      end
      if (state == prk4_pkg::ST_KSUM) begin
        group <= (stage_n == 2'd3) ? prk4_pkg::GRP_FINAL : prk4_pkg::GRP_STAGE;
        idx   <= '0;
      end

      // output register
      if (state == prk4_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == prk4_pkg::ST_IDLE && in_acc) begin
      h_step <= time_step;
      for (int i = 0; i < 4; i++) begin
        tmp[i] <= cur[i];
      end
    end

    // product, and the copied derivative terms at the start of an evaluation
    if (state == prk4_pkg::ST_MUL) begin
      prod <= prod_full[prk4_pkg::PROD_W-1:0];
      if (group == prk4_pkg::GRP_DERIV && idx == 2'd0) begin
        der[0] <= tmp[1];
        der[2] <= tmp[3];
      end
    end

    if (state == prk4_pkg::ST_RND) begin
      rnd <= rnd_next;
      rem <= '0;
    end

    if (state == prk4_pkg::ST_DIV) begin
      rnd <= {rnd[RW-DB-1:0], div_q};
      rem <= div_rem;
    end

    if (state == prk4_pkg::ST_ACC) begin
      case (op.dest)
        prk4_pkg::DST_ACC:   acc      <= acc_sum;
        prk4_pkg::DST_D1:    der[1]   <= acc_sat;
        prk4_pkg::DST_D3:    der[3]   <= acc_sat;
        prk4_pkg::DST_STAGE: tmp[idx] <= acc_sat;
        default: ;
      endcase
    end

    // weighted slope sum k1 + 2*k2 + 2*k3 + k4
    if (state == prk4_pkg::ST_KSUM) begin
      for (int i = 0; i < 4; i++) begin
        logic signed [SW-1:0] d_ext;
        logic signed [SW-1:0] d_term;
        d_ext  = {{(SW-CW){der[i][CW-1]}}, der[i]};
        d_term = (stage_n == 2'd1 || stage_n == 2'd2) ? (d_ext <<< 1) : d_ext;
        ksum[i] <= ((stage_n == 2'd0) ? '0 : ksum[i]) + d_term;
      end
    end

    if (state == prk4_pkg::ST_DONE && out_free) begin
      pos_x  <= cur[0];
      vel_x  <= cur[1];
      pos_y  <= cur[2];
      vel_y  <= cur[3];
      landed <= ground_hit;
    end
  end

  // checks
  `PRK4_ASSERT_NEXT(a_launch_loads, clk, rst, (in_acc && command == prk4_pkg::CMD_LAUNCH), (!ground_hit && cur[0] == $past(start_x) && state == prk4_pkg::ST_DONE))
  `PRK4_ASSERT_SAME(a_div_final_only, clk, rst, (state == prk4_pkg::ST_DIV), (group == prk4_pkg::GRP_FINAL))
  `PRK4_ASSERT_SAME(a_ksum_after_deriv, clk, rst, (state == prk4_pkg::ST_KSUM), (group == prk4_pkg::GRP_DERIV && idx == 2'd3))

endmodule
